/* rtl/tbcs_pkg.sv */
package tbcs_pkg;

    localparam int COORD_WIDTH_DEF = 32;

endpackage

/* rtl/tbcs_sqrt_stage.sv */
// One step of the floored square root: tries one result bit per stage.
module tbcs_sqrt_stage
    import tbcs_pkg::*;
#(
    parameter int CW  = COORD_WIDTH_DEF,
    parameter int BIT = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid_in,
    input  logic [2*CW+1:0]   rem_in,
    input  logic [CW:0]       root_in,
    input  logic [CW-1:0]     cx_in,
    input  logic [CW-1:0]     cy_in,
    input  logic [CW-1:0]     cz_in,
    input  logic              last_in_s,
    output logic              valid_out,
    output logic [2*CW+1:0]   rem_out,
    output logic [CW:0]       root_out,
    output logic [CW-1:0]     cx_out,
    output logic [CW-1:0]     cy_out,
    output logic [CW-1:0]     cz_out,
    output logic              last_out_s
);

    // Restoring method: remainder kept, trial = (2*root + 2^bit) << bit
    logic [2*CW+3:0] trial;
    logic [2*CW+3:0] rem_ext;
    logic            take;
    logic [2*CW+1:0] rem_next;
    logic [CW:0]     root_next;
    logic            valid_reg;
    logic [2*CW+1:0] rem_reg;
    logic [CW:0]     root_reg;
    logic [CW-1:0]   cx_reg;
    logic [CW-1:0]   cy_reg;
    logic [CW-1:0]   cz_reg;
    logic            last_reg;

    always_comb
    begin
        trial     = ({{(CW+3){1'b0}}, root_in} << (BIT + 1))
                  | ({{(2*CW+3){1'b0}}, 1'b1} << (2 * BIT));
        rem_ext   = {2'b00, rem_in};
        take      = (trial <= rem_ext);
        rem_next  = take ? (2*CW+2)'(rem_ext - trial) : rem_in;
        root_next = take ? (root_in | ({{CW{1'b0}}, 1'b1} << BIT)) : root_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            cx_reg   <= cx_in;
            cy_reg   <= cy_in;
            cz_reg   <= cz_in;
            last_reg <= last_in_s;
        end
    end

    assign valid_out  = valid_reg;
    assign rem_out    = rem_reg;
    assign root_out   = root_reg;
    assign cx_out     = cx_reg;
    assign cy_out     = cy_reg;
    assign cz_out     = cz_reg;
    assign last_out_s = last_reg;

endmodule

/* rtl/triangle_box_center_sphere_core.sv */
// Triangle bounding sphere, box-center method.
// Input channel: one triangle per item (three vertices, signed Q.16 coords)
//   plus last_in; accepted when in_valid is high and in_stall is low.
// Output channel: center_x/y/z, radius and last_out; taken when out_valid is
//   high and out_stall is low. One result per triangle, in order.
// Pipeline: box and center (1), differences (1), squares (1), sum (1),
//   largest squared distance (1), then one stage per square-root bit
//   (COORD_WIDTH+1), then the output register. The square-root chain makes
//   up most of the depth.
// Throughput: one item per cycle while the output is not stalled.
// Stall: a stall on the output freezes the whole pipeline together; in_stall
//   follows out_stall while the output holds an item. Nothing is lost.
// Reset: asynchronous, clears all valid bits; the pipeline starts empty.
// Note the largest distance is the root of the largest squared distance,
//   identical to the largest of the floored roots.
module triangle_box_center_sphere_core
    import tbcs_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] v1_x,
    input  logic signed [COORD_WIDTH-1:0] v1_y,
    input  logic signed [COORD_WIDTH-1:0] v1_z,
    input  logic signed [COORD_WIDTH-1:0] v2_x,
    input  logic signed [COORD_WIDTH-1:0] v2_y,
    input  logic signed [COORD_WIDTH-1:0] v2_z,
    input  logic signed [COORD_WIDTH-1:0] v3_x,
    input  logic signed [COORD_WIDTH-1:0] v3_y,
    input  logic signed [COORD_WIDTH-1:0] v3_z,
    input  logic                          last_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_WIDTH-1:0] center_x,
    output logic signed [COORD_WIDTH-1:0] center_y,
    output logic signed [COORD_WIDTH-1:0] center_z,
    output logic        [COORD_WIDTH-1:0] radius,
    output logic                          last_out
);

    localparam int CW  = COORD_WIDTH;
    localparam int NSQ = CW + 1;
    localparam int SW  = 2 * CW + 2;

    logic en;
    logic out_valid_reg;

    // whole pipeline advances unless a held result is stalled
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // ---------------- stage 1: box and center
    logic signed [CW-1:0] vin [3][3];
    logic signed [CW-1:0] c_next [3];
    logic signed [CW-1:0] c1_reg [3];
    logic signed [CW-1:0] v1_reg [3][3];
    logic                 s1_valid_reg;
    logic                 s1_last_reg;

    always_comb
    begin
        logic signed [CW-1:0] lo;
        logic signed [CW-1:0] hi;
        logic signed [CW:0]   s;
        vin[0][0] = v1_x; vin[0][1] = v1_y; vin[0][2] = v1_z;
        vin[1][0] = v2_x; vin[1][1] = v2_y; vin[1][2] = v2_z;
        vin[2][0] = v3_x; vin[2][1] = v3_y; vin[2][2] = v3_z;
        for (int a = 0; a < 3; a++)
        begin
            lo = vin[0][a];
            hi = vin[0][a];
            for (int k = 1; k < 3; k++)
            begin
                if (vin[k][a] < lo) lo = vin[k][a];
                if (vin[k][a] > hi) hi = vin[k][a];
            end
            s = {lo[CW-1], lo} + {hi[CW-1], hi};
            c_next[a] = s[CW:1];
        end
    end

    // ---------------- stage 2: absolute differences
    logic [CW-1:0]   d2_reg [3][3];
    logic signed [CW-1:0] c2_reg [3];
    logic            s2_valid_reg;
    logic            s2_last_reg;
    logic [CW-1:0]   d_next [3][3];

    always_comb
    begin
        logic signed [CW:0] d;
        for (int k = 0; k < 3; k++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                d = {c1_reg[a][CW-1], c1_reg[a]} - {v1_reg[k][a][CW-1], v1_reg[k][a]};
                d_next[k][a] = d[CW] ? CW'(-d) : d[CW-1:0];
            end
        end
    end

    // ---------------- stage 3: squares
    logic [2*CW-1:0] q3_reg [3][3];
    logic signed [CW-1:0] c3_reg [3];
    logic            s3_valid_reg;
    logic            s3_last_reg;

    // ---------------- stage 4: sums
    logic [SW-1:0]   sum4_reg [3];
    logic signed [CW-1:0] c4_reg [3];
    logic            s4_valid_reg;
    logic            s4_last_reg;

    // ---------------- stage 5: largest squared distance
    logic [SW-1:0]   max5_reg;
    logic signed [CW-1:0] c5_reg [3];
    logic            s5_valid_reg;
    logic            s5_last_reg;
    logic [SW-1:0]   max_next;

    always_comb
    begin
        max_next = sum4_reg[0];
        if (sum4_reg[1] > max_next) max_next = sum4_reg[1];
        if (sum4_reg[2] > max_next) max_next = sum4_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg      <= c_next;
            v1_reg      <= vin;
            s1_last_reg <= last_in;
            d2_reg      <= d_next;
            c2_reg      <= c1_reg;
            s2_last_reg <= s1_last_reg;
            for (int k = 0; k < 3; k++)
                for (int a = 0; a < 3; a++)
                    q3_reg[k][a] <= d2_reg[k][a] * d2_reg[k][a];
            c3_reg      <= c2_reg;
            s3_last_reg <= s2_last_reg;
            for (int k = 0; k < 3; k++)
                sum4_reg[k] <= SW'(q3_reg[k][0]) + SW'(q3_reg[k][1]) + SW'(q3_reg[k][2]);
            c4_reg      <= c3_reg;
            s4_last_reg <= s3_last_reg;
            max5_reg    <= max_next;
            c5_reg      <= c4_reg;
            s5_last_reg <= s4_last_reg;
        end
    end

    // ---------------- square-root chain, MSB first
    logic            sq_valid [NSQ+1];
    logic [SW-1:0]   sq_rem   [NSQ+1];
    logic [CW:0]     sq_root  [NSQ+1];
    logic [CW-1:0]   sq_cx    [NSQ+1];
    logic [CW-1:0]   sq_cy    [NSQ+1];
    logic [CW-1:0]   sq_cz    [NSQ+1];
    logic            sq_last  [NSQ+1];

    assign sq_valid[0] = s5_valid_reg;
    assign sq_rem[0]   = max5_reg;
    assign sq_root[0]  = '0;
    assign sq_cx[0]    = c5_reg[0];
    assign sq_cy[0]    = c5_reg[1];
    assign sq_cz[0]    = c5_reg[2];
    assign sq_last[0]  = s5_last_reg;

    for (genvar i = 0; i < NSQ; i++)
    begin : g_sqrt
        tbcs_sqrt_stage #(
            .CW  (CW),
            .BIT (CW - i)
        ) u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .valid_in   (sq_valid[i]),
            .rem_in     (sq_rem[i]),
            .root_in    (sq_root[i]),
            .cx_in      (sq_cx[i]),
            .cy_in      (sq_cy[i]),
            .cz_in      (sq_cz[i]),
            .last_in_s  (sq_last[i]),
            .valid_out  (sq_valid[i+1]),
            .rem_out    (sq_rem[i+1]),
            .root_out   (sq_root[i+1]),
            .cx_out     (sq_cx[i+1]),
            .cy_out     (sq_cy[i+1]),
            .cz_out     (sq_cz[i+1]),
            .last_out_s (sq_last[i+1])
        );
    end

    // ---------------- output register
    logic [CW-1:0] cx_out_reg;
    logic [CW-1:0] cy_out_reg;
    logic [CW-1:0] cz_out_reg;
    logic [CW-1:0] rad_out_reg;
    logic          last_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= sq_valid[NSQ];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_out_reg   <= sq_cx[NSQ];
            cy_out_reg   <= sq_cy[NSQ];
            cz_out_reg   <= sq_cz[NSQ];
            rad_out_reg  <= sq_root[NSQ][CW-1:0];
            last_out_reg <= sq_last[NSQ];
        end
    end

    assign out_valid = out_valid_reg;
    assign center_x  = cx_out_reg;
    assign center_y  = cy_out_reg;
    assign center_z  = cz_out_reg;
    assign radius    = rad_out_reg;
    assign last_out  = last_out_reg;

endmodule
